// ----- src/bgl_pkg.sv -----
// ----------------------------------------------------------------------------
// bgl_pkg: shared types and constants for the gcd / lcm block
// Field width of the words on both channels and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package bgl_pkg;

  // width of every operand, gcd and lcm field on the channels
  localparam int FIELD_W = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STRIP,
    S_XODD,
    S_LOOP,
    S_DIV,
    S_MUL,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- src/bgl_in_if.sv -----
// ----------------------------------------------------------------------------
// bgl_in_if: operand channel
// Valid / ready channel carrying one pair of operands per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgl_in_if;

  logic                        valid;
  logic                        ready;
  logic [bgl_pkg::FIELD_W-1:0] first_value;
  logic [bgl_pkg::FIELD_W-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);

endinterface

`default_nettype wire

// ----- src/bgl_out_if.sv -----
// ----------------------------------------------------------------------------
// bgl_out_if: result channel
// Valid / ready channel carrying gcd, lcm and overflow flag per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgl_out_if;

  logic                        valid;
  logic                        ready;
  logic [bgl_pkg::FIELD_W-1:0] common_divisor;
  logic [bgl_pkg::FIELD_W-1:0] common_multiple;
  logic                        overflowed;

  modport source (output valid, output common_divisor, output common_multiple,
                  output overflowed, input ready);
  modport sink   (input valid, input common_divisor, input common_multiple,
                  input overflowed, output ready);

endinterface

`default_nettype wire

// ----- src/bgl_alu.sv -----
// ----------------------------------------------------------------------------
// bgl_alu: shared add / subtract unit
// One adder used for gcd compare-subtract, division trial and multiply step.
// ----------------------------------------------------------------------------
`default_nettype none

module bgl_alu #(
  parameter int WIDTH = 65
) (
  input  wire logic [WIDTH-1:0] op_a_i,
  input  wire logic [WIDTH-1:0] op_b_i,
  input  wire logic             sub_i,
  output logic      [WIDTH-1:0] res_o,
  output logic                  carry_o   // on subtract: set when no borrow
);

  logic [WIDTH:0] sum;

  always_comb begin
    sum = {1'b0, op_a_i} + {1'b0, (sub_i ? ~op_b_i : op_b_i)} + {{WIDTH{1'b0}}, sub_i};
  end

  assign res_o   = sum[WIDTH-1:0];
  assign carry_o = sum[WIDTH];

endmodule

`default_nettype wire

// ----- src/binary_gcd_lcm.sv -----
// ----------------------------------------------------------------------------
// binary_gcd_lcm: binary gcd and exact lcm with overflow flag
// Stein's gcd, then lcm = (a / gcd) * b by restoring division and
// shift-add multiplication, all on one shared adder.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            word
//  -------  ---  -------------------  -----------------------------------------
//  in_i     in   valid / ready        first_value, second_value
//  out_o    out  valid / ready        common_divisor, common_multiple, overflowed
//
// one word at a time; in_i.ready is high only while the sequencer is idle
// a word with a zero operand goes straight to the final state; otherwise the
//   sequencer strips shared twos, then lone twos, runs the gcd steps, then the
//   restoring divide and the shift-add multiply, the compare-subtract, divide
//   and multiply steps all going through the single adder
// the result sits in an output register, so a new word is taken while it waits
// a stalled output holds the sequencer in its final state until the register frees
// reset clears the sequencer and the output valid; payload registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module binary_gcd_lcm #(
  parameter int OPERAND_WIDTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bgl_in_if.sink    in_i,
  bgl_out_if.source out_o
);

  localparam int W  = OPERAND_WIDTH;
  localparam int AW = W + 1;               // adder width
  localparam int CW = $clog2(W + 1);       // step counter
  localparam int TW = $clog2(W);           // shared twos count, at most W-1
  localparam int FW = bgl_pkg::FIELD_W;

  // sequencer
  bgl_pkg::state_e state_q, state_d;

  // working registers
  logic [W-1:0]  x_q, x_d;       // gcd x, then remainder, then lcm accumulator
  logic [W-1:0]  y_q, y_d;       // gcd y, then the finished gcd
  logic [W-1:0]  a_q, a_d;       // first operand, then quotient
  logic [W-1:0]  b_q, b_d;       // second operand, multiplicand
  logic [TW-1:0] twos_q, twos_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic [W-1:0]  gcd_out_q, lcm_out_q;
  logic          ovf_out_q;
  logic          out_load;

  // shared adder
  logic [AW-1:0] alu_a, alu_b, alu_res;
  logic          alu_sub, alu_carry;

  logic [W-1:0]  op_a, op_b;
  logic          in_fire;
  logic          last_step;

  assign op_a      = in_i.first_value[W-1:0];
  assign op_b      = in_i.second_value[W-1:0];
  assign in_i.ready = (state_q == bgl_pkg::S_IDLE);
  assign in_fire   = in_i.valid && in_i.ready;
  assign last_step = (cnt_q == CW'(W - 1));
  assign out_load  = (state_q == bgl_pkg::S_DONE) && (!out_valid_q || out_o.ready);

  bgl_alu #(
    .WIDTH (AW)
  ) u_alu (
    .op_a_i  (alu_a),
    .op_b_i  (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  // adder operand steering
  always_comb begin
    alu_a   = {1'b0, y_q};
    alu_b   = {1'b0, x_q};
    alu_sub = 1'b1;
    case (state_q)
      bgl_pkg::S_DIV: begin
        // trial subtract of the divisor from the shifted remainder
        alu_a   = {x_q, a_q[W-1]};
        alu_b   = {1'b0, y_q};
        alu_sub = 1'b1;
      end
      bgl_pkg::S_MUL: begin
        // msb-first shift-add: acc = 2*acc + bit*b
        alu_a   = {x_q, 1'b0};
        alu_b   = {1'b0, (a_q[W-1] ? b_q : '0)};
        alu_sub = 1'b0;
      end
      default: begin
        // gcd compare-subtract: y - x, carry set when y >= x
        alu_a   = {1'b0, y_q};
        alu_b   = {1'b0, x_q};
        alu_sub = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bgl_pkg::S_IDLE: begin
        if (in_fire) begin
          if (op_a == '0 || op_b == '0) begin
            state_d = bgl_pkg::S_DONE;
          end else begin
            state_d = bgl_pkg::S_STRIP;
          end
        end
      end
      bgl_pkg::S_STRIP: begin
        if (x_q[0] || y_q[0]) begin
          state_d = bgl_pkg::S_XODD;
        end
      end
      bgl_pkg::S_XODD: begin
        if (x_q[0]) begin
          state_d = bgl_pkg::S_LOOP;
        end
      end
      bgl_pkg::S_LOOP: begin
        if (y_q == '0) begin
          state_d = bgl_pkg::S_DIV;
        end
      end
      bgl_pkg::S_DIV: begin
        if (last_step) begin
          state_d = bgl_pkg::S_MUL;
        end
      end
      bgl_pkg::S_MUL: begin
        if (last_step) begin
          state_d = bgl_pkg::S_DONE;
        end
      end
      bgl_pkg::S_DONE: begin
        if (out_load) begin
          state_d = bgl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bgl_pkg::S_IDLE;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    a_d    = a_q;
    b_d    = b_q;
    twos_d = twos_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    case (state_q)
      bgl_pkg::S_IDLE: begin
        if (in_fire) begin
          a_d    = op_a;
          b_d    = op_b;
          twos_d = '0;
          ovf_d  = 1'b0;
          if (op_a == '0 || op_b == '0) begin
            // gcd is the other operand, lcm is zero
            x_d = '0;
            y_d = op_a | op_b;
          end else begin
            x_d = op_a;
            y_d = op_b;
          end
        end
      end
      bgl_pkg::S_STRIP: begin
        if (!(x_q[0] || y_q[0])) begin
          x_d    = x_q >> 1;
          y_d    = y_q >> 1;
          twos_d = twos_q + TW'(1);
        end
      end
      bgl_pkg::S_XODD: begin
        if (!x_q[0]) begin
          x_d = x_q >> 1;
        end
      end
      bgl_pkg::S_LOOP: begin
        if (y_q == '0) begin
          // restore shared twos, clear remainder for the divide
          y_d   = x_q << twos_q;
          x_d   = '0;
          cnt_d = '0;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (!alu_carry) begin
          // x > y: swap, subtract next cycle
          x_d = y_q;
          y_d = x_q;
        end else begin
          y_d = alu_res[W-1:0];
        end
      end
      bgl_pkg::S_DIV: begin
        a_d   = {a_q[W-2:0], alu_carry};
        x_d   = alu_carry ? alu_res[W-1:0] : alu_a[W-1:0];
        cnt_d = cnt_q + CW'(1);
        if (last_step) begin
          cnt_d = '0;
          ovf_d = 1'b0;
        end
      end
      bgl_pkg::S_MUL: begin
        // quotient holds a / gcd; accumulate lcm into x
        a_d   = a_q << 1;
        x_d   = alu_res[W-1:0];
        ovf_d = ovf_q | alu_res[W] | alu_carry;
        cnt_d = cnt_q + CW'(1);
      end
      default: begin
      end
    endcase
    // the divide leaves the quotient in a and a dirty x; start the product clean
    if (state_q == bgl_pkg::S_DIV && last_step) begin
      x_d = '0;
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bgl_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    a_q    <= a_d;
    b_q    <= b_d;
    twos_q <= twos_d;
    cnt_q  <= cnt_d;
    ovf_q  <= ovf_d;
    if (out_load) begin
      gcd_out_q <= y_q;
      lcm_out_q <= ovf_q ? '1 : x_q;
      ovf_out_q <= ovf_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.common_divisor  = FW'(gcd_out_q);
  assign out_o.common_multiple = FW'(lcm_out_q);
  assign out_o.overflowed      = ovf_out_q;

endmodule

`default_nettype wire

// ----- src/bgl_checker.sv -----
// ----------------------------------------------------------------------------
// bgl_checker: port-level checks for the gcd / lcm block
// Watches the two channels of the top level; bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module bgl_checker #(
  parameter int OPERAND_WIDTH = 64
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [bgl_pkg::FIELD_W-1:0] out_divisor_i,
  input wire logic [bgl_pkg::FIELD_W-1:0] out_multiple_i,
  input wire logic                        out_overflowed_i
);

  localparam int FW = bgl_pkg::FIELD_W;

  logic [FW-1:0] lcm_sat;
  assign lcm_sat = FW'({OPERAND_WIDTH{1'b1}});

  // a word waiting on the output stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // a stalled output word keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_divisor_i) && $stable(out_multiple_i)
      && $stable(out_overflowed_i))
    else $error("output word changed while stalled");

  // an accepted operand pair keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("operands accepted while busy");

  // overflow saturates the lcm
  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_overflowed_i |-> out_multiple_i == lcm_sat)
    else $error("overflow without saturated lcm");

  // a nonzero lcm comes with a nonzero gcd
  a_lcm_has_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_multiple_i != '0 |-> out_divisor_i != '0)
    else $error("nonzero lcm with zero gcd");

endmodule

bind binary_gcd_lcm bgl_checker #(
  .OPERAND_WIDTH (OPERAND_WIDTH)
) u_bgl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_divisor_i    (out_o.common_divisor),
  .out_multiple_i   (out_o.common_multiple),
  .out_overflowed_i (out_o.overflowed)
);

`default_nettype wire
